[hdl/tsl_pkg.sv]
package tsl_pkg;

    localparam int unsigned POS_W    = 11;
    localparam int unsigned TEMP_W   = 8;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned CFG_W    = 11;
    localparam int unsigned IN_DW    = 56;
    localparam int unsigned IN_UW    = 1;
    localparam int unsigned OUT_DW   = 24;

    localparam logic [POS_W-1:0] POS_MAX = 11'd1024;

    // Operation codes carried in s_tuser
    typedef enum logic [0:0] {
        OP_INIT = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_WARM_TEMP_LIMIT     = 3'd0,
        REG_COLD_TEMP_LIMIT     = 3'd1,
        REG_WARM_OPEN_GUARD     = 3'd2,
        REG_COLD_OPEN_GUARD     = 3'd3,
        REG_CLOSED_FLOOR        = 3'd4,
        REG_CLOSED_LOWER_OFFSET = 3'd5,
        REG_OPEN_RAISE_OFFSET   = 3'd6,
        REG_BYPASS_ENABLE       = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [TEMP_W-1:0] warm_temp_limit;
        logic [TEMP_W-1:0] cold_temp_limit;
        logic [POS_W-1:0]  warm_open_guard;
        logic [POS_W-1:0]  cold_open_guard;
        logic [POS_W-1:0]  closed_floor;
        logic [POS_W-1:0]  closed_lower_offset;
        logic [POS_W-1:0]  open_raise_offset;
        logic              bypass_enable;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic [TEMP_W-1:0] ecu_temperature;
        logic              limp_home;
        logic [POS_W-1:0]  limp_home_pos;
        logic [POS_W-1:0]  demand_pos;
        logic [POS_W-1:0]  closed_stop_pos;
        logic [POS_W-1:0]  open_stop_pos;
        logic              learn_active;
        logic              floor_inhibit;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0] position_reference;
        logic             temp_protected;
        logic             temp_protect_mode;
        logic [POS_W-1:0] open_guard_used;
    } result_t;

    // Saturate a 12-bit sum to the position range
    function automatic logic [POS_W-1:0] cap_sum(input logic [POS_W:0] v);
        logic [POS_W-1:0] r;
        r = (v > {1'b0, POS_MAX}) ? POS_MAX : v[POS_W-1:0];
        return r;
    endfunction

    // Saturate an 11-bit value to the position range
    function automatic logic [POS_W-1:0] cap_pos(input logic [POS_W-1:0] v);
        logic [POS_W-1:0] r;
        r = (v > POS_MAX) ? POS_MAX : v;
        return r;
    endfunction

    // a - b clamped to 0..POS_MAX
    function automatic logic [POS_W-1:0] sub_clamp(input logic [POS_W-1:0] a,
                                                   input logic [POS_W-1:0] b);
        logic [POS_W-1:0] r;
        r = (a > b) ? cap_pos(a - b) : '0;
        return r;
    endfunction

endpackage

[hdl/tsl_cfg.sv]
module tsl_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tsl_pkg::IDX_W-1:0]   cfg_index,
    input  logic [tsl_pkg::CFG_W-1:0]   cfg_data,
    output tsl_pkg::cfg_t               cfg
);
    import tsl_pkg::*;

    cfg_t cfg_reg;

    // Register file, written one register per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{warm_temp_limit: 8'd255, default: '0};
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_WARM_TEMP_LIMIT:     cfg_reg.warm_temp_limit     <= cfg_data[TEMP_W-1:0];
                REG_COLD_TEMP_LIMIT:     cfg_reg.cold_temp_limit     <= cfg_data[TEMP_W-1:0];
                REG_WARM_OPEN_GUARD:     cfg_reg.warm_open_guard     <= cfg_data[POS_W-1:0];
                REG_COLD_OPEN_GUARD:     cfg_reg.cold_open_guard     <= cfg_data[POS_W-1:0];
                REG_CLOSED_FLOOR:        cfg_reg.closed_floor        <= cfg_data[POS_W-1:0];
                REG_CLOSED_LOWER_OFFSET: cfg_reg.closed_lower_offset <= cfg_data[POS_W-1:0];
                REG_OPEN_RAISE_OFFSET:   cfg_reg.open_raise_offset   <= cfg_data[POS_W-1:0];
                REG_BYPASS_ENABLE:       cfg_reg.bypass_enable       <= cfg_data[0];
                default:                 cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/tsl_calc.sv]
module tsl_calc #(
    parameter int unsigned BYPASS_CLOSED_POS = 0
) (
    input  tsl_pkg::in_item_t             item,
    input  tsl_pkg::cfg_t                 cfg,
    input  logic [tsl_pkg::POS_W-1:0]     held_guard,
    output logic [tsl_pkg::POS_W-1:0]     held_guard_next,
    output tsl_pkg::result_t              res
);
    import tsl_pkg::*;

    localparam logic [POS_W-1:0] BYPASS_POS = (BYPASS_CLOSED_POS > 1024) ? POS_MAX
                                              : POS_W'(BYPASS_CLOSED_POS);

    logic [POS_W-1:0] guard_sel;
    logic [POS_W-1:0] guard_tick;
    logic [POS_W-1:0] closed_eff;
    logic [POS_W-1:0] open_eff;
    logic [POS_W-1:0] rel_pos;
    logic [POS_W-1:0] floored;
    logic [POS_W-1:0] abs_pos;
    logic [POS_W-1:0] open_cap;
    logic [POS_W-1:0] tick_pos;
    logic             tick_mode;

    // Guard selection with temperature hysteresis; warm test wins
    always_comb
    begin
        priority if (item.ecu_temperature > cfg.warm_temp_limit)
            guard_sel = cfg.warm_open_guard;
        else if (item.ecu_temperature <= cfg.cold_temp_limit)
            guard_sel = cfg.cold_open_guard;
        else
            guard_sel = held_guard;
    end

    assign guard_tick = cap_pos(guard_sel);
    assign tick_mode  = (guard_tick == cfg.warm_open_guard);

    // Effective stops: widened while learning, otherwise the capped stop positions
    always_comb
    begin
        if (item.learn_active)
        begin
            closed_eff = cfg.bypass_enable ? BYPASS_POS
                         : sub_clamp(item.closed_stop_pos, cfg.closed_lower_offset);
            open_eff   = cap_sum({1'b0, item.open_stop_pos} + {1'b0, cfg.open_raise_offset});
        end
        else
        begin
            closed_eff = cap_pos(item.closed_stop_pos);
            open_eff   = cap_pos(item.open_stop_pos);
        end
    end

    // Floor, offset by the closed stop, cap below the guarded open stop
    assign rel_pos  = item.limp_home ? item.limp_home_pos : item.demand_pos;
    assign floored  = (!item.floor_inhibit && rel_pos < cfg.closed_floor) ? cfg.closed_floor
                      : rel_pos;
    assign abs_pos  = cap_sum({1'b0, floored} + {1'b0, closed_eff});
    assign open_cap = sub_clamp(open_eff, guard_tick);
    assign tick_pos = (abs_pos > open_cap) ? open_cap : abs_pos;

    // Result select by operation
    always_comb
    begin
        unique case (item.op)
            OP_INIT:
            begin
                held_guard_next        = held_guard;
                res.position_reference = cap_sum({1'b0, item.demand_pos}
                                                 + {1'b0, item.closed_stop_pos});
                res.temp_protected     = 1'b0;
                res.temp_protect_mode  = (held_guard == cfg.warm_open_guard);
                res.open_guard_used    = held_guard;
            end
            default:
            begin
                held_guard_next        = guard_tick;
                res.position_reference = tick_pos;
                res.temp_protected     = (tick_pos == open_cap) && tick_mode;
                res.temp_protect_mode  = tick_mode;
                res.open_guard_used    = guard_tick;
            end
        endcase
    end

endmodule

[hdl/throttle_setpoint_limiter.sv]
// Input register, then result register, lie between input transaction and result.
// Throughput: one transaction per cycle while m_tready does not stall the output; the
// held-guard update is a loop through the guard select and cap logic in tsl_calc.
// Reset (rst_n, async, active low): pipeline empty, held guard 0, warm_temp_limit 255,
// all other configuration registers 0.
module throttle_setpoint_limiter #(
    parameter int unsigned BYPASS_CLOSED_POS = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [tsl_pkg::IDX_W-1:0]     cfg_index,
    input  logic [tsl_pkg::CFG_W-1:0]     cfg_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // ecu_temperature[7:0], limp_home[8], limp_home_pos[19:9], demand_pos[30:20],
    // closed_stop_pos[41:31], open_stop_pos[52:42], learn_active[53], floor_inhibit[54]
    input  logic [tsl_pkg::IN_DW-1:0]     s_tdata,
    // op[0]
    input  logic [tsl_pkg::IN_UW-1:0]     s_tuser,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // position_reference[10:0], temp_protected[11], temp_protect_mode[12],
    // open_guard_used[23:13]
    output logic [tsl_pkg::OUT_DW-1:0]    m_tdata
);
    import tsl_pkg::*;

    cfg_t             cfg;
    in_item_t         in_item;
    in_item_t         item_reg;
    logic             item_vld_reg;
    result_t          res_next;
    result_t          res_reg;
    logic             res_vld_reg;
    logic [POS_W-1:0] held_guard_reg;
    logic [POS_W-1:0] held_guard_next;
    logic             advance;

    tsl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tsl_calc #(
        .BYPASS_CLOSED_POS (BYPASS_CLOSED_POS)
    ) u_calc (
        .item            (item_reg),
        .cfg             (cfg),
        .held_guard      (held_guard_reg),
        .held_guard_next (held_guard_next),
        .res             (res_next)
    );

    // Unpack input transaction
    always_comb
    begin
        in_item.op              = op_t'(s_tuser[0]);
        in_item.ecu_temperature = s_tdata[7:0];
        in_item.limp_home       = s_tdata[8];
        in_item.limp_home_pos   = s_tdata[19:9];
        in_item.demand_pos      = s_tdata[30:20];
        in_item.closed_stop_pos = s_tdata[41:31];
        in_item.open_stop_pos   = s_tdata[52:42];
        in_item.learn_active    = s_tdata[53];
        in_item.floor_inhibit   = s_tdata[54];
    end

    // Pipeline flow control
    assign advance  = item_vld_reg && (!res_vld_reg || m_tready);
    assign s_tready = !item_vld_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_vld_reg <= 1'b0;
        else if (s_tready)
            item_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            item_reg <= in_item;
    end

    // Result register and held guard
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg    <= 1'b0;
            held_guard_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                res_vld_reg    <= 1'b1;
                held_guard_reg <= held_guard_next;
            end
            else if (m_tready)
                res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign m_tvalid = res_vld_reg;
    assign m_tdata  = {res_reg.open_guard_used, res_reg.temp_protect_mode,
                       res_reg.temp_protected, res_reg.position_reference};

    // Held guard moves only when a tick leaves the input register
    a_guard_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && item_reg.op == OP_TICK) |=> $stable(held_guard_reg))
        else $error("held guard changed without a tick");

    // Held guard never exceeds full scale
    a_guard_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_guard_reg <= POS_MAX)
        else $error("held guard above full scale");

    // Delivered reference within range
    a_ref_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> res_reg.position_reference <= POS_MAX)
        else $error("position reference above full scale");

    // Input stalls only when both stages are occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (item_vld_reg && res_vld_reg))
        else $error("input stalled with free stage");

endmodule
